[sv/lin_pkg.sv]
// ----------------------------------------------------------------------------
// lin_pkg
// Shared types and constants of the leaky integrator neuron bank.
// ----------------------------------------------------------------------------
`default_nettype none

package lin_pkg;

   localparam int FUNC_BITS     = 2;
   localparam int NEURON_BITS   = 8;
   localparam int VALUE_BITS    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int LEAK_BITS     = FRAC_BITS + 1;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [LEAK_BITS-1:0] LEAK_ONE = LEAK_BITS'(1 << FRAC_BITS);

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_APPLY     = 2'd0,
      FUNC_LOAD_LEAK = 2'd1,
      FUNC_CLEAR     = 2'd2,
      FUNC_LOAD_PREV = 2'd3
   } func_type;

   typedef struct packed {
      logic                   valid;
      logic                   apply;
      logic [NEURON_BITS-1:0] neuron;
   } stage_type;

endpackage

`default_nettype wire

[sv/leaky_integrator_neuron_bank.sv]
// ----------------------------------------------------------------------------
// leaky_integrator_neuron_bank
// Bank of first-order leaky integrators, one per neuron, state held in RAM.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless a stalled response or a hazard holds it. An
// apply returns delta*prev + (1-delta)*sample through three pipeline stages,
// the last one loading the output register, and stores it as the neuron's new
// previous output. The previous output is read from RAM when the item is taken
// and written back after the multiply and round stages, so an apply or load
// previous to a neuron that one of the two items just ahead of it also writes
// waits; the write landing in the same cycle as the read is forwarded. Deltas
// are clamped to 1.0 on load and must be loaded before a neuron is applied.
// Clear takes effect at once through per-neuron valid flops, with no sweep.
// Items naming a neuron at or above NEURONS (at most 256) are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module leaky_integrator_neuron_bank #(
   parameter int NEURONS = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // neuron [7:0], sample [39:8], leak [56:40], zero [63:57]
   input  wire logic [lin_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // func [1:0]
   input  wire logic [lin_pkg::FUNC_BITS-1:0]     req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // neuron_out [7:0], filtered [39:8]
   output logic      [lin_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int NB = lin_pkg::NEURON_BITS;
   localparam int VB = lin_pkg::VALUE_BITS;
   localparam int LB = lin_pkg::LEAK_BITS;
   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int RSP_DATA_BITS_L = lin_pkg::RSP_DATA_BITS;

   lin_pkg::func_type    req_func;
   logic [NB-1:0]        req_neuron;
   logic signed [VB-1:0] req_sample;
   logic [LB-1:0]        req_leak;
   logic [LB-1:0]        leak_clamped;
   logic [AW-1:0]        req_addr;
   logic                 in_range;
   logic                 writes_prev;
   logic                 hazard;
   logic                 advance;
   logic                 accept;

   lin_pkg::stage_type   s1_in, s1_ff, s2_ff, s3_ff;
   logic signed [VB-1:0] s1_sample_ff;
   logic                 s1_known_ff;

   logic [NEURONS-1:0]   prev_valid_in, prev_valid_ff;

   logic                 lw_valid_ff;
   logic [NB-1:0]        lw_neuron_ff;
   logic signed [VB-1:0] lw_data_ff;

   logic [LB-1:0]        leak_rd;
   logic [VB-1:0]        prev_rd;
   logic signed [VB-1:0] prev_s1;
   logic [LB-1:0]        leak_s1;
   logic signed [VB-1:0] result;
   logic                 prev_wr;

   logic                 rsp_valid_in, rsp_valid_ff;
   logic [RSP_DATA_BITS_L-1:0] rsp_data_ff;

   assign req_func   = lin_pkg::func_type'(req_tuser);
   assign req_neuron = req_tdata[NB-1:0];
   assign req_sample = $signed(req_tdata[NB +: VB]);
   assign req_leak   = req_tdata[NB + VB +: LB];
   assign req_addr   = AW'(req_neuron);
   assign in_range   = (int'(req_neuron) < NEURONS);

   assign leak_clamped = (req_leak > lin_pkg::LEAK_ONE) ? lin_pkg::LEAK_ONE : req_leak;

   assign writes_prev = in_range &&
                        ((req_func == lin_pkg::FUNC_APPLY) ||
                         (req_func == lin_pkg::FUNC_LOAD_PREV));

   // write-back of s1 and s2 not yet in ram
   assign hazard = writes_prev &&
                   ((s1_ff.valid && (s1_ff.neuron == req_neuron)) ||
                    (s2_ff.valid && (s2_ff.neuron == req_neuron)));

   assign advance    = !(s3_ff.valid && s3_ff.apply && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance && !hazard;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_in.valid  = accept && writes_prev;
      s1_in.apply  = (req_func == lin_pkg::FUNC_APPLY);
      s1_in.neuron = req_neuron;
   end

   always_comb begin
      prev_valid_in = prev_valid_ff;
      if (accept) begin
         if (req_func == lin_pkg::FUNC_CLEAR) begin
            prev_valid_in = '0;
         end else if (writes_prev) begin
            prev_valid_in[req_addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= '0;
         s1_ff         <= '0;
         s2_ff         <= '0;
         s3_ff         <= '0;
      end else begin
         prev_valid_ff <= prev_valid_in;
         if (advance) begin
            s1_ff <= s1_in;
            s2_ff <= s1_ff;
            s3_ff <= s2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample;
         s1_known_ff  <= prev_valid_ff[req_addr];
      end
   end

   lin_ram #(
      .WIDTH (LB),
      .DEPTH (NEURONS)
   ) u_leak_ram (
      .clock   (clock),
      .wr_en   (accept && in_range && (req_func == lin_pkg::FUNC_LOAD_LEAK)),
      .wr_addr (req_addr),
      .wr_data (leak_clamped),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (leak_rd)
   );

   assign prev_wr = advance && s3_ff.valid;

   lin_ram #(
      .WIDTH (VB),
      .DEPTH (NEURONS)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr),
      .wr_addr (AW'(s3_ff.neuron)),
      .wr_data (result),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (prev_rd)
   );

   // last write-back, for a read issued at the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (prev_wr) begin
         lw_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_wr) begin
         lw_neuron_ff <= s3_ff.neuron;
         lw_data_ff   <= result;
      end
   end

   always_comb begin
      if (!s1_known_ff) begin
         prev_s1 = '0;
      end else if (lw_valid_ff && (lw_neuron_ff == s1_ff.neuron)) begin
         prev_s1 = lw_data_ff;
      end else begin
         prev_s1 = $signed(prev_rd);
      end
   end

   // load previous passes the sample through with delta zero
   assign leak_s1 = s1_ff.apply ? leak_rd : '0;

   lin_calc u_calc (
      .clock        (clock),
      .advance      (advance),
      .prev_value   (prev_s1),
      .sample_value (s1_sample_ff),
      .leak_value   (leak_s1),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && s3_ff.valid && s3_ff.apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s3_ff.valid && s3_ff.apply) begin
         rsp_data_ff <= {result, s3_ff.neuron};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[sv/lin_ram.sv]
// ----------------------------------------------------------------------------
// lin_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_ram #(
   parameter  int WIDTH     = 32,
   parameter  int DEPTH     = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/lin_calc.sv]
// ----------------------------------------------------------------------------
// lin_calc
// Integrator arithmetic: difference, multiply by delta, round and add back.
// ----------------------------------------------------------------------------
`default_nettype none

module lin_calc (
   input  wire logic                                clock,
   input  wire logic                                advance,
   input  wire logic signed [lin_pkg::VALUE_BITS-1:0] prev_value,
   input  wire logic signed [lin_pkg::VALUE_BITS-1:0] sample_value,
   input  wire logic        [lin_pkg::LEAK_BITS-1:0]  leak_value,
   output logic      signed [lin_pkg::VALUE_BITS-1:0] result
);

   localparam int VB        = lin_pkg::VALUE_BITS;
   localparam int FB        = lin_pkg::FRAC_BITS;
   localparam int LB        = lin_pkg::LEAK_BITS;
   localparam int PROD_BITS = VB + 1 + LB + 1;

   localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1 << (FB - 1));

   logic signed [VB:0]          diff_in;
   logic signed [VB:0]          diff_ff;
   logic        [LB-1:0]        leak_ff;
   logic signed [VB-1:0]        x2_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [VB-1:0]        x3_ff;
   logic signed [PROD_BITS-1:0] rounded;

   assign diff_in = {prev_value[VB-1], prev_value} - {sample_value[VB-1], sample_value};
   assign prod_in = diff_ff * $signed({1'b0, leak_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
         leak_ff <= leak_value;
         x2_ff   <= sample_value;
         prod_ff <= prod_in;
         x3_ff   <= x2_ff;
      end
   end

   // scaled product rounded to nearest, ties rounded up
   assign rounded = prod_ff + HALF;
   assign result  = x3_ff + $signed(rounded[FB +: VB]);

endmodule

`default_nettype wire
